/* design/gct4_pkg.sv */
// ----------------------------------------------------------------------------
// gct4_pkg: shared types and constants for the grid change top-four selector
// Field widths, list slot types, register indexes and reset values.
// ----------------------------------------------------------------------------
package gct4_pkg;

   localparam int SCORE_BITS     = 16;
   localparam int ROW_BITS       = 3;
   localparam int COL_BITS       = 3;
   localparam int TOP_COUNT      = 4;
   localparam int RANK_BITS      = 2;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [SCORE_BITS-1:0] CHANGE_THRESHOLD_RESET = 16'd655;
   localparam logic [SCORE_BITS-1:0] SCORE_FLOOR_RESET      = 16'd655;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHANGE_THRESHOLD = 8'd0,
      CSR_SCORE_FLOOR      = 8'd1
   } csr_index_type;

   // one entry of the sorted list
   typedef struct packed {
      logic                  full;
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      logic [SCORE_BITS-1:0] value;
   } slot_type;

   typedef slot_type [TOP_COUNT-1:0] list_type;

   // scored cell handed from the front stage to the list
   typedef struct packed {
      logic                  valid;
      logic                  final_cell;
      logic                  qualify;
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      logic [SCORE_BITS-1:0] value;
   } cand_type;

endpackage

/* design/gct4_if.sv */
// ----------------------------------------------------------------------------
// gct4 channel interfaces
// Valid/ready channels for cell requests, ranked results and register writes.
// ----------------------------------------------------------------------------
interface gct4_req_if;
   logic                              valid;
   logic                              ready;
   logic [gct4_pkg::ROW_BITS-1:0]     cell_row;
   logic [gct4_pkg::COL_BITS-1:0]     cell_col;
   logic [gct4_pkg::SCORE_BITS-1:0]   prior_score;
   logic [gct4_pkg::SCORE_BITS-1:0]   later_score;
   logic                              final_cell;

   modport source (output valid, cell_row, cell_col, prior_score, later_score,
                   final_cell, input ready);
   modport sink   (input valid, cell_row, cell_col, prior_score, later_score,
                   final_cell, output ready);
endinterface

interface gct4_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gct4_pkg::RANK_BITS-1:0]    rank;
   logic                              found;
   logic [gct4_pkg::ROW_BITS-1:0]     hit_row;
   logic [gct4_pkg::COL_BITS-1:0]     hit_col;
   logic [gct4_pkg::SCORE_BITS-1:0]   change_value;
   logic                              last_result;

   modport source (output valid, rank, found, hit_row, hit_col, change_value,
                   last_result, input ready);
   modport sink   (input valid, rank, found, hit_row, hit_col, change_value,
                   last_result, output ready);
endinterface

interface gct4_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [gct4_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [gct4_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/grid_change_top4_select_top.sv */
// ----------------------------------------------------------------------------
// grid_change_top4_select_top: streaming top-four grid change selector
// Scores each grid cell and keeps the four largest changes until the scan ends.
// ----------------------------------------------------------------------------
// The block takes one cell request per clock unless a final cell is held.
// A cell waits in the input register, where its floored scores are
// differenced and, if the change reaches the threshold, inserted into the
// sorted four-entry list. A cell marked final copies the list into the
// result buffer, which then sends four responses, rank 0 to rank 3, one per
// cycle while the response side is ready; new cells keep flowing into the
// cleared list meanwhile. A final cell waits in the input register only
// while the previous scan's four responses are still in the buffer. Register
// writes are taken at any cycle and should be made while the block is idle.
// ----------------------------------------------------------------------------
module grid_change_top4_select_top (
   input  logic       clock,
   input  logic       reset,
   gct4_req_if.sink   req_bus,
   gct4_rsp_if.source rsp_bus,
   gct4_csr_if.sink   csr_bus
);

   logic [gct4_pkg::SCORE_BITS-1:0] change_threshold_ff;
   logic [gct4_pkg::SCORE_BITS-1:0] score_floor_ff;
   gct4_pkg::cand_type              cand;
   gct4_pkg::list_type              list_next;
   logic                            out_busy;
   logic                            take;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         change_threshold_ff <= gct4_pkg::CHANGE_THRESHOLD_RESET;
         score_floor_ff      <= gct4_pkg::SCORE_FLOOR_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            gct4_pkg::CSR_CHANGE_THRESHOLD: change_threshold_ff <= csr_bus.data;
            gct4_pkg::CSR_SCORE_FLOOR:      score_floor_ff      <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // hold a final cell until the result buffer has drained
   assign take = cand.valid && (!cand.final_cell || !out_busy);

   gct4_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .change_threshold (change_threshold_ff),
      .score_floor      (score_floor_ff),
      .take             (take),
      .cand             (cand)
   );

   gct4_list u_list (
      .clock     (clock),
      .reset     (reset),
      .cand      (cand),
      .take      (take),
      .list_next (list_next)
   );

   gct4_out u_out (
      .clock (clock),
      .reset (reset),
      .load  (take && cand.final_cell),
      .slots (list_next),
      .busy  (out_busy),
      .rsp   (rsp_bus)
   );

endmodule

/* design/gct4_front.sv */
// ----------------------------------------------------------------------------
// gct4_front: input register and change scoring
// Registers one cell request, floors both scores, forms the absolute
// difference and tests it against the change threshold.
// ----------------------------------------------------------------------------
module gct4_front (
   input  logic                            clock,
   input  logic                            reset,
   gct4_req_if.sink                        req,
   input  logic [gct4_pkg::SCORE_BITS-1:0] change_threshold,
   input  logic [gct4_pkg::SCORE_BITS-1:0] score_floor,
   input  logic                            take,
   output gct4_pkg::cand_type              cand
);

   logic                            vld_ff, vld_in;
   logic [gct4_pkg::ROW_BITS-1:0]   row_ff;
   logic [gct4_pkg::COL_BITS-1:0]   col_ff;
   logic [gct4_pkg::SCORE_BITS-1:0] before_ff;
   logic [gct4_pkg::SCORE_BITS-1:0] after_ff;
   logic                            final_ff;
   logic [gct4_pkg::SCORE_BITS-1:0] before_fl;
   logic [gct4_pkg::SCORE_BITS-1:0] after_fl;
   logic [gct4_pkg::SCORE_BITS-1:0] diff;
   logic                            load;

   // the held request leaves whenever the list takes it
   assign req.ready = !vld_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff    <= req.cell_row;
         col_ff    <= req.cell_col;
         before_ff <= req.prior_score;
         after_ff  <= req.later_score;
         final_ff  <= req.final_cell;
      end
   end

   always_comb begin
      before_fl = (before_ff < score_floor) ? '0 : before_ff;
      after_fl  = (after_ff < score_floor) ? '0 : after_ff;
      diff      = (before_fl >= after_fl) ? (before_fl - after_fl)
                                          : (after_fl - before_fl);
   end

   always_comb begin
      cand.valid      = vld_ff;
      cand.final_cell = final_ff;
      cand.qualify    = (diff >= change_threshold);
      cand.row        = row_ff;
      cand.col        = col_ff;
      cand.value      = diff;
   end

endmodule

/* design/gct4_list.sv */
// ----------------------------------------------------------------------------
// gct4_list: sorted top-four list
// Inserts a qualifying change with a parallel compare and shift, hands the
// updated list to the result buffer on the last cell and clears itself.
// ----------------------------------------------------------------------------
module gct4_list (
   input  logic               clock,
   input  logic               reset,
   input  gct4_pkg::cand_type cand,
   input  logic               take,
   output gct4_pkg::list_type list_next
);

   gct4_pkg::list_type                list_ff, list_in;
   gct4_pkg::slot_type                new_slot;
   logic [gct4_pkg::TOP_COUNT-1:0]    ge;
   logic                              ins;

   assign ins = take && cand.qualify;

   always_comb begin
      new_slot.full  = 1'b1;
      new_slot.row   = cand.row;
      new_slot.col   = cand.col;
      new_slot.value = cand.value;

      // an empty slot ranks lowest; an equal value goes above the older one
      for (int i = 0; i < gct4_pkg::TOP_COUNT; i++) begin
         ge[i] = !list_ff[i].full || (cand.value >= list_ff[i].value);
      end

      list_next[0] = (ins && ge[0]) ? new_slot : list_ff[0];
      for (int i = 1; i < gct4_pkg::TOP_COUNT; i++) begin
         if (ins && ge[i]) begin
            list_next[i] = ge[i-1] ? list_ff[i-1] : new_slot;
         end else begin
            list_next[i] = list_ff[i];
         end
      end

      list_in = list_next;
      if (take && cand.final_cell) begin
         list_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_ff <= '0;
      end else begin
         list_ff <= list_in;
      end
   end

endmodule

/* design/gct4_out.sv */
// ----------------------------------------------------------------------------
// gct4_out: result buffer
// Holds a snapshot of the finished list and sends it out one rank per
// response, rank 0 first.
// ----------------------------------------------------------------------------
module gct4_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  gct4_pkg::list_type slots,
   output logic               busy,
   gct4_rsp_if.source         rsp
);

   gct4_pkg::list_type             buf_ff;
   logic                           busy_ff, busy_in;
   logic [gct4_pkg::RANK_BITS-1:0] rank_ff, rank_in;
   gct4_pkg::slot_type             cur;
   logic                           last;
   logic                           send;

   assign busy = busy_ff;
   assign cur  = buf_ff[rank_ff];
   assign last = (rank_ff == gct4_pkg::RANK_BITS'(gct4_pkg::TOP_COUNT - 1));
   assign send = rsp.valid && rsp.ready;

   always_comb begin
      busy_in = busy_ff;
      rank_in = rank_ff;
      if (load) begin
         busy_in = 1'b1;
         rank_in = '0;
      end else if (send) begin
         if (last) begin
            busy_in = 1'b0;
            rank_in = '0;
         end else begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rank_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         rank_ff <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= slots;
      end
   end

   // empty ranks report zero fields
   always_comb begin
      rsp.valid        = busy_ff;
      rsp.rank         = rank_ff;
      rsp.found        = cur.full;
      rsp.hit_row      = cur.full ? cur.row : '0;
      rsp.hit_col      = cur.full ? cur.col : '0;
      rsp.change_value = cur.full ? cur.value : '0;
      rsp.last_result  = last;
   end

endmodule

/* design/gct4_checker.sv */
// ----------------------------------------------------------------------------
// gct4_checker: port-level checks for the grid change selector
// Watches the response channel for quiet after reset, stall holding, rank order, the last mark and empty-rank contents.
// ----------------------------------------------------------------------------
module gct4_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [gct4_pkg::RANK_BITS-1:0]  rsp_rank,
   input logic                            rsp_found,
   input logic [gct4_pkg::ROW_BITS-1:0]   rsp_hit_row,
   input logic [gct4_pkg::COL_BITS-1:0]   rsp_hit_col,
   input logic [gct4_pkg::SCORE_BITS-1:0] rsp_change_value,
   input logic                            rsp_last_result
);

   // no stale response right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rank)))
      else $error("stalled response dropped or changed rank");

   // ranks of one scan come out back to back and in order
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_result) |=>
      (rsp_valid && (rsp_rank == $past(rsp_rank) + 1'b1)))
      else $error("rank sequence broken");

   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_last_result ==
       (rsp_rank == gct4_pkg::RANK_BITS'(gct4_pkg::TOP_COUNT - 1))))
      else $error("last mark not on final rank");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
      (rsp_hit_row == '0 && rsp_hit_col == '0 && rsp_change_value == '0))
      else $error("empty rank carries data");

endmodule

bind grid_change_top4_select_top gct4_checker u_gct4_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_rank         (rsp_bus.rank),
   .rsp_found        (rsp_bus.found),
   .rsp_hit_row      (rsp_bus.hit_row),
   .rsp_hit_col      (rsp_bus.hit_col),
   .rsp_change_value (rsp_bus.change_value),
   .rsp_last_result  (rsp_bus.last_result)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the grid change top-four selector
// Streams grid cells through the request channel, keeps its own sorted
// four-entry change list, and checks every ranked response in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IDLE_PCT     = 31;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 31;
   localparam int PHASE_COUNT  = 6;
   localparam int MAX_REPORTS  = 10;
   localparam int TIMEOUT_TIME = 400000;

   typedef struct packed {
      logic [gct4_pkg::ROW_BITS-1:0]   row;
      logic [gct4_pkg::COL_BITS-1:0]   col;
      logic [gct4_pkg::SCORE_BITS-1:0] prior;
      logic [gct4_pkg::SCORE_BITS-1:0] later;
      logic                            last;
   } grid_cell_type;

   typedef struct packed {
      logic [gct4_pkg::RANK_BITS-1:0]  rank;
      logic                            found;
      logic [gct4_pkg::ROW_BITS-1:0]   row;
      logic [gct4_pkg::COL_BITS-1:0]   col;
      logic [gct4_pkg::SCORE_BITS-1:0] value;
      logic                            last;
   } ranked_hit_type;

   typedef struct packed {
      bit                              set_regs;
      logic [gct4_pkg::SCORE_BITS-1:0] threshold;
      logic [gct4_pkg::SCORE_BITS-1:0] floor_level;
      logic [gct4_pkg::ROW_BITS-1:0]   row;
      logic [gct4_pkg::COL_BITS-1:0]   col;
      logic [gct4_pkg::SCORE_BITS-1:0] prior;
      logic [gct4_pkg::SCORE_BITS-1:0] later;
      bit                              last;
      bit                              typed;
      logic                            top_found;
      logic [gct4_pkg::ROW_BITS-1:0]   top_row;
      logic [gct4_pkg::COL_BITS-1:0]   top_col;
      logic [gct4_pkg::SCORE_BITS-1:0] top_value;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   gct4_req_if req_bus ();
   gct4_rsp_if rsp_bus ();
   gct4_csr_if csr_bus ();

   grid_change_top4_select_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   logic [gct4_pkg::SCORE_BITS-1:0] cfg_threshold;
   logic [gct4_pkg::SCORE_BITS-1:0] cfg_floor;
   gct4_pkg::list_type              ranking;
   ranked_hit_type                  pending_hits [$];
   int                              mismatch_count = 0;
   bit                              steady_run = 1'b0;

   // set_regs, threshold, floor, row, col, prior, later, last,
   // typed, top found, top row, top col, top value
   directed_row_type directed_rows [25] = '{
      // empty list straight after reset
      '{1'b0, 16'd0, 16'd0, 3'd0, 3'd0, 16'h0000, 16'h0000, 1'b1,
        1'b1, 1'b0, 3'd0, 3'd0, 16'h0000},
      // full-scale changes, equal values: the newer cell wins
      '{1'b0, 16'd0, 16'd0, 3'd7, 3'd7, 16'hFFFF, 16'h0000, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd0, 3'd0, 16'h0000, 16'hFFFF, 1'b1,
        1'b1, 1'b1, 3'd0, 3'd0, 16'hFFFF},
      // scores just under and at the floor, change just under threshold
      '{1'b0, 16'd0, 16'd0, 3'd2, 3'd1, 16'd654, 16'd0, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd2, 3'd2, 16'd655, 16'd0, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd2, 3'd3, 16'd654, 16'd1310, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd2, 3'd4, 16'd2000, 16'd2654, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      // more than four changes: the smallest ones fall out
      '{1'b0, 16'd0, 16'd0, 3'd5, 3'd5, 16'd0, 16'd9000, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd6, 3'd6, 16'd30000, 16'd0, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd4, 3'd4, 16'd12000, 16'd2000, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd3, 3'd3, 16'd500, 16'd40000, 1'b1,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      // zero threshold: a zero change still counts
      '{1'b1, 16'h0000, 16'h0000, 3'd3, 3'd5, 16'd1234, 16'd1234, 1'b1,
        1'b1, 1'b1, 3'd3, 3'd5, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd1, 3'd2, 16'd0, 16'd0, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd7, 3'd0, 16'd0, 16'd1, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd0, 3'd7, 16'd1, 16'd0, 1'b1,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      // both registers at full scale
      '{1'b1, 16'hFFFF, 16'hFFFF, 3'd1, 3'd1, 16'hFFFE, 16'hFFFF, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd6, 3'd6, 16'hFFFF, 16'hFFFE, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd5, 3'd5, 16'hFFFF, 16'hFFFF, 1'b1,
        1'b1, 1'b1, 3'd6, 3'd6, 16'hFFFF},
      // nothing reaches a full-scale threshold
      '{1'b1, 16'hFFFF, 16'h0000, 3'd2, 3'd6, 16'h0000, 16'hFFFE, 1'b1,
        1'b1, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b1, 16'd100, 16'h0000, 3'd5, 3'd2, 16'h5555, 16'hAAAA, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd2, 3'd5, 16'hAAAA, 16'h5555, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd7, 3'd3, 16'd0, 16'd200, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd3, 3'd7, 16'd300, 16'd0, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd6, 3'd1, 16'd1000, 16'd1100, 1'b0,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000},
      '{1'b0, 16'd0, 16'd0, 3'd1, 3'd6, 16'd0, 16'd99, 1'b1,
        1'b0, 1'b0, 3'd0, 3'd0, 16'h0000}
   };

   // Fold one accepted cell into the list; a final cell releases four ranks.
   task automatic score_cell(input grid_cell_type c);
      logic [gct4_pkg::SCORE_BITS-1:0] b;
      logic [gct4_pkg::SCORE_BITS-1:0] a;
      logic [gct4_pkg::SCORE_BITS-1:0] change;
      ranked_hit_type                  hit;
      int                              pos;
      int                              i;
      b = (c.prior < cfg_floor) ? '0 : c.prior;
      a = (c.later < cfg_floor) ? '0 : c.later;
      change = (b >= a) ? b - a : a - b;
      if (change >= cfg_threshold) begin
         pos = gct4_pkg::TOP_COUNT;
         for (i = gct4_pkg::TOP_COUNT - 1; i >= 0; i--)
            if (!ranking[i].full || change >= ranking[i].value) pos = i;
         if (pos < gct4_pkg::TOP_COUNT) begin
            for (i = gct4_pkg::TOP_COUNT - 1; i > pos; i--) ranking[i] = ranking[i - 1];
            ranking[pos] = '{full: 1'b1, row: c.row, col: c.col, value: change};
         end
      end
      if (c.last) begin
         for (i = 0; i < gct4_pkg::TOP_COUNT; i++) begin
            hit.rank  = gct4_pkg::RANK_BITS'(i);
            hit.found = ranking[i].full;
            hit.row   = ranking[i].full ? ranking[i].row : '0;
            hit.col   = ranking[i].full ? ranking[i].col : '0;
            hit.value = ranking[i].full ? ranking[i].value : '0;
            hit.last  = (i == gct4_pkg::TOP_COUNT - 1);
            pending_hits.push_back(hit);
         end
         ranking = '0;
      end
   endtask

   task automatic send_cell(input grid_cell_type c);
      if (!steady_run) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid       <= 1'b1;
      req_bus.cell_row    <= c.row;
      req_bus.cell_col    <= c.col;
      req_bus.prior_score <= c.prior;
      req_bus.later_score <= c.later;
      req_bus.final_cell  <= c.last;
      do @(posedge clock); while (!req_bus.ready);
      score_cell(c);
   endtask

   // Hold requests until the last rank is out and the input stage is empty.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers, then poke an unused index that must be ignored.
   task automatic program_regs(input logic [gct4_pkg::SCORE_BITS-1:0] threshold,
                               input logic [gct4_pkg::SCORE_BITS-1:0] floor_level);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= gct4_pkg::CSR_CHANGE_THRESHOLD;
      csr_bus.data  <= threshold;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_threshold = threshold;
      csr_bus.index <= gct4_pkg::CSR_SCORE_FLOOR;
      csr_bus.data  <= floor_level;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_floor = floor_level;
      csr_bus.index <= gct4_pkg::CSR_INDEX_BITS'(
                          $urandom_range(gct4_pkg::CSR_SCORE_FLOOR + 1,
                                         2**gct4_pkg::CSR_INDEX_BITS - 1));
      csr_bus.data  <= gct4_pkg::CSR_DATA_BITS'($urandom);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [gct4_pkg::SCORE_BITS-1:0] pick_score();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return cfg_floor + gct4_pkg::SCORE_BITS'($urandom_range(0, 2)) - 1'b1;
         default: return gct4_pkg::SCORE_BITS'($urandom);
      endcase
   endfunction

   function automatic grid_cell_type random_cell(input bit last);
      grid_cell_type                   c;
      logic [gct4_pkg::SCORE_BITS-1:0] step;
      c.row   = gct4_pkg::ROW_BITS'($urandom_range(0, 7));
      c.col   = gct4_pkg::COL_BITS'($urandom_range(0, 7));
      c.prior = pick_score();
      case ($urandom_range(0, 3))
         0: c.later = pick_score();
         1: c.later = c.prior;
         default: begin
            // land the change on or right beside the threshold
            step = cfg_threshold + gct4_pkg::SCORE_BITS'($urandom_range(0, 2)) - 1'b1;
            c.later = $urandom_range(0, 1) ? c.prior + step : c.prior - step;
         end
      endcase
      c.last = last;
      return c;
   endfunction

   task automatic flag_mismatch(input string what, input ranked_hit_type want,
                                input ranked_hit_type got);
      if (mismatch_count < MAX_REPORTS)
         $display("rank result mismatch (%s): expected rank=%0d found=%0d row=%0d col=%0d",
                  what, want.rank, want.found, want.row, want.col,
                  " value=%h last=%0d, got rank=%0d found=%0d row=%0d col=%0d",
                  want.value, want.last, got.rank, got.found, got.row, got.col,
                  " value=%h last=%0d", got.value, got.last);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      ranked_hit_type got;
      ranked_hit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rank: rsp_bus.rank, found: rsp_bus.found, row: rsp_bus.hit_row,
                 col: rsp_bus.hit_col, value: rsp_bus.change_value,
                 last: rsp_bus.last_result};
         if (pending_hits.size() == 0) begin
            flag_mismatch("no result pending", '0, got);
         end else begin
            want = pending_hits.pop_front();
            if (got !== want) flag_mismatch("wrong field", want, got);
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !reset && (steady_run || $urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      #TIMEOUT_TIME;
      $display("grid_change_top4_select_top test failed");
      $finish;
   end

   initial begin
      grid_cell_type c;
      int            n;
      int            idx;
      int            phase;
      int            sent;
      int            scan_len;
      bit            broken;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.cell_row    = '0;
      req_bus.cell_col    = '0;
      req_bus.prior_score = '0;
      req_bus.later_score = '0;
      req_bus.final_cell  = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      cfg_threshold       = gct4_pkg::CHANGE_THRESHOLD_RESET;
      cfg_floor           = gct4_pkg::SCORE_FLOOR_RESET;
      ranking             = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].set_regs) begin
            drain_results();
            program_regs(directed_rows[n].threshold, directed_rows[n].floor_level);
         end
         c = '{row: directed_rows[n].row, col: directed_rows[n].col,
               prior: directed_rows[n].prior, later: directed_rows[n].later,
               last: directed_rows[n].last};
         send_cell(c);
         if (directed_rows[n].typed) begin
            idx = pending_hits.size() - gct4_pkg::TOP_COUNT;
            pending_hits[idx].found = directed_rows[n].top_found;
            pending_hits[idx].row   = directed_rows[n].top_row;
            pending_hits[idx].col   = directed_rows[n].top_col;
            pending_hits[idx].value = directed_rows[n].top_value;
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         case (phase)
            0: program_regs(gct4_pkg::CHANGE_THRESHOLD_RESET,
                            gct4_pkg::SCORE_FLOOR_RESET);
            1: program_regs('0, '0);
            2: program_regs('1, '1);
            3: program_regs(gct4_pkg::SCORE_BITS'($urandom_range(0, 4000)),
                            gct4_pkg::SCORE_BITS'($urandom_range(0, 4000)));
            default: program_regs(gct4_pkg::SCORE_BITS'($urandom),
                                  gct4_pkg::SCORE_BITS'($urandom_range(0, 2000)));
         endcase
         steady_run = (phase == 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // most scans close with a final cell; a few run on into the next
            scan_len = $urandom_range(1, 10);
            broken   = ($urandom_range(0, 7) == 0);
            for (n = 1; n <= scan_len; n++) begin
               send_cell(random_cell(n == scan_len && !broken));
               sent++;
            end
         end
      end

      steady_run = 1'b0;
      drain_results();
      if (mismatch_count == 0)
         $display("grid_change_top4_select_top test passed");
      else
         $display("grid_change_top4_select_top test failed");
      $finish;
   end

endmodule

/* grid_change_top4_select_top.f */
design/gct4_pkg.sv
design/gct4_if.sv
design/gct4_front.sv
design/gct4_list.sv
design/gct4_out.sv
design/grid_change_top4_select_top.sv
design/gct4_checker.sv
sim/tb_top.sv
